// File: rtl/core/pno_pkg.sv
// polyline normal offset: shared payload types and fixed-point constants
// used by rtl/core/polyline_normal_offset.sv, no dependencies
package pno_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_last;
  } pno_in_t;

  typedef struct packed {
    logic signed [31:0] shifted_x;
    logic signed [31:0] shifted_y;
    logic signed [31:0] shifted_z;
    logic               shifted_last;
  } pno_out_t;

  // floor(1e-6 * 2^60), cosine threshold on the q60 dot product
  localparam logic signed [63:0] CosLimitQ60 = 64'sd1152921504606;
  // clamp for the q46 shift product
  localparam logic [83:0] ProdLimit = 84'd1 << 62;
  localparam logic [62:0] RoundHalfQ30 = 63'd1 << 29;

endpackage

// File: rtl/core/polyline_normal_offset.sv
// polyline normal offset, top level: sequencer around one multiplier,
// one restoring divider and one square root step; depends on pno_pkg
//
// usage: points of an open polyline come in on the in channel (valid/ready),
// point_last closes the polyline. each point is moved along its left normal by
// offset_distance, written on the cfg channel (always ready, reset 0).
// results leave one point late: the first point of a line gives no beat,
// every later point releases the result of the point before it, and the last
// point releases two beats. a line of one point comes out unchanged.
// one item at a time: in_ready_o is high only while the sequencer is idle.
// an edge normal takes a normalizing shift, a 32-step square root and two
// 64-step divisions; an interior point adds a second normalization and, for a
// miter, two more 64-step divisions on the one-bit-per-cycle divider. each
// result beat adds two multiplies per coordinate.
// the output register holds a beat while out_ready_i is low and the
// sequencer waits for it. reset clears the held points and the offset.
module polyline_normal_offset
  import pno_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pno_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pno_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [31:0] cfg_data_i
);

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StStart  = 5'd1;
  localparam logic [4:0] StPass   = 5'd2;
  localparam logic [4:0] StUInit  = 5'd3;
  localparam logic [4:0] StUNorm  = 5'd4;
  localparam logic [4:0] StUSqa   = 5'd5;
  localparam logic [4:0] StUSqb   = 5'd6;
  localparam logic [4:0] StUSqs   = 5'd7;
  localparam logic [4:0] StUSqrt  = 5'd8;
  localparam logic [4:0] StUDiva  = 5'd9;
  localparam logic [4:0] StUDivb  = 5'd10;
  localparam logic [4:0] StUEnd   = 5'd11;
  localparam logic [4:0] StDiv    = 5'd12;
  localparam logic [4:0] StDota   = 5'd13;
  localparam logic [4:0] StDotb   = 5'd14;
  localparam logic [4:0] StDots   = 5'd15;
  localparam logic [4:0] StMdivx  = 5'd16;
  localparam logic [4:0] StMdivy  = 5'd17;
  localparam logic [4:0] StMdend  = 5'd18;
  localparam logic [4:0] StMlo    = 5'd19;
  localparam logic [4:0] StMhi    = 5'd20;
  localparam logic [4:0] StMacc   = 5'd21;
  localparam logic [4:0] StEmit   = 5'd22;

  logic [4:0]         st_q, div_ret_q;
  logic [1:0]         held_q;
  logic signed [31:0] off_q;
  pno_in_t            p_q;
  logic signed [31:0] pend_x_q, pend_y_q, pend_z_q;
  logic signed [31:0] n1x_q, n1y_q, n2x_q, n2y_q;
  logic signed [52:0] nx_q, ny_q;
  logic               phase_sum_q;   // unit vector of the normal sum, not of an edge
  logic               emit_sel_q;    // second beat of a last point
  logic               cy_q;          // working on the y coordinate
  logic signed [33:0] a_q, b_q;
  logic [32:0]        ma_q, mb_q;
  logic [63:0]        prod_q, acc_q, lo_q;
  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
  logic [63:0]        div_n_q, div_quo_q;
  logic [31:0]        div_d_q, div_r_q, len_q, qa_q;
  logic [31:0]        cq_q;
  logic [5:0]         cnt_q;
  logic signed [31:0] sx_q, sy_q;
  logic               out_valid_q;
  pno_out_t           out_q;

  logic [31:0]        mul_a, mul_b;
  logic [32:0]        m_max;
  logic [63:0]        sq_t;
  logic [32:0]        div_t;
  logic               div_ge;
  logic signed [52:0] n_sel;
  logic [51:0]        n_mag;
  logic [31:0]        off_mag;
  logic               shift_neg;
  logic [83:0]        full_prod;
  logic [62:0]        clamp_prod;
  logic [32:0]        delta_mag;
  logic signed [34:0] coord_sum;
  logic signed [31:0] coord_sel, coord_sat;
  logic signed [63:0] dot;
  logic signed [63:0] pdot_a;
  logic               out_free;
  logic               out_load;

  assign in_ready_o  = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  // a new beat enters the output register this cycle
  assign out_load    = out_free && ((st_q == StPass) || (st_q == StEmit));

  // multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (st_q)
      StUSqa: begin
        mul_a = ma_q[31:0];
        mul_b = ma_q[31:0];
      end
      StUSqb: begin
        mul_a = mb_q[31:0];
        mul_b = mb_q[31:0];
      end
      StDota: begin
        mul_a = n1x_q[31] ? 32'(-n1x_q) : n1x_q;
        mul_b = nx_q[52] ? 32'(-nx_q) : nx_q[31:0];
      end
      StDotb: begin
        mul_a = n1y_q[31] ? 32'(-n1y_q) : n1y_q;
        mul_b = ny_q[52] ? 32'(-ny_q) : ny_q[31:0];
      end
      StMlo: begin
        mul_a = n_mag[31:0];
        mul_b = off_mag;
      end
      StMhi: begin
        mul_a = {12'd0, n_mag[51:32]};
        mul_b = off_mag;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    m_max  = (ma_q > mb_q) ? ma_q : mb_q;
    sq_t   = sq_res_q + sq_bit_q;
    div_t  = {div_r_q, div_n_q[63]};
    div_ge = (div_t >= {1'b0, div_d_q});
    // signed dot contributions: product of magnitudes with the sign put back
    pdot_a = ((n1x_q[31] ^ nx_q[52]) ? -$signed(acc_q) : $signed(acc_q));
    dot    = pdot_a + ((n1y_q[31] ^ ny_q[52]) ? -$signed(prod_q) : $signed(prod_q));
  end

  // coordinate shift: |n| * |off| clamped, rounded to q16, saturating add
  always_comb begin
    n_sel      = cy_q ? ny_q : nx_q;
    n_mag      = n_sel[52] ? 52'(-n_sel) : n_sel[51:0];
    off_mag    = off_q[31] ? 32'(-off_q) : off_q;
    shift_neg  = n_sel[52] ^ off_q[31];
    full_prod  = {prod_q[51:0], 32'd0} + {20'd0, lo_q};
    clamp_prod = (full_prod > ProdLimit) ? ProdLimit[62:0] : full_prod[62:0];
    delta_mag  = 33'((clamp_prod + RoundHalfQ30) >> 30);
    if (emit_sel_q) begin
      coord_sel = cy_q ? p_q.point_y : p_q.point_x;
    end else begin
      coord_sel = cy_q ? pend_y_q : pend_x_q;
    end
    coord_sum = shift_neg ? (35'(coord_sel) - $signed({2'b00, delta_mag}))
                          : (35'(coord_sel) + $signed({2'b00, delta_mag}));
    if (coord_sum > 35'sd2147483647) begin
      coord_sat = 32'sh7fffffff;
    end else if (coord_sum < -35'sd2147483648) begin
      coord_sat = 32'sh80000000;
    end else begin
      coord_sat = coord_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      held_q      <= 2'd0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
      div_ret_q   <= StIdle;
    end else begin
      if (cfg_valid_i) begin
        off_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            p_q  <= in_data_i;
            st_q <= StStart;
          end
        end
        StStart: begin
          if (held_q == 2'd0) begin
            if (p_q.point_last) begin
              st_q <= StPass;
            end else begin
              pend_x_q <= p_q.point_x;
              pend_y_q <= p_q.point_y;
              pend_z_q <= p_q.point_z;
              held_q   <= 2'd1;
              st_q     <= StIdle;
            end
          end else begin
            a_q         <= 34'(p_q.point_x) - 34'(pend_x_q);
            b_q         <= 34'(p_q.point_y) - 34'(pend_y_q);
            phase_sum_q <= 1'b0;
            emit_sel_q  <= 1'b0;
            st_q        <= StUInit;
          end
        end
        StPass: begin
          if (out_free) begin
            out_q.shifted_x    <= p_q.point_x;
            out_q.shifted_y    <= p_q.point_y;
            out_q.shifted_z    <= p_q.point_z;
            out_q.shifted_last <= 1'b1;
            out_valid_q        <= 1'b1;
            st_q               <= StIdle;
          end
        end
        StUInit: begin
          ma_q <= a_q[33] ? 33'(-a_q) : a_q[32:0];
          mb_q <= b_q[33] ? 33'(-b_q) : b_q[32:0];
          if (a_q == '0 && b_q == '0) begin
            qa_q      <= '0;
            div_quo_q <= '0;
            st_q      <= StUEnd;
          end else begin
            st_q <= StUNorm;
          end
        end
        StUNorm: begin
          // one bit per cycle until the larger magnitude sits in [2^30, 2^31)
          if (m_max[32:31] != 2'b00) begin
            ma_q <= ma_q >> 1;
            mb_q <= mb_q >> 1;
          end else if (!m_max[30]) begin
            ma_q <= ma_q << 1;
            mb_q <= mb_q << 1;
          end else begin
            st_q <= StUSqa;
          end
        end
        StUSqa: st_q <= StUSqb;
        StUSqb: begin
          acc_q <= prod_q;
          st_q  <= StUSqs;
        end
        StUSqs: begin
          sq_v_q   <= acc_q + prod_q;
          sq_res_q <= '0;
          sq_bit_q <= 64'd1 << 62;
          cnt_q    <= '0;
          st_q     <= StUSqrt;
        end
        StUSqrt: begin
          if (sq_v_q >= sq_t) begin
            sq_v_q   <= sq_v_q - sq_t;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          cnt_q    <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            st_q <= StUDiva;
          end
        end
        StUDiva: begin
          len_q     <= sq_res_q[31:0];
          div_n_q   <= {ma_q[30:0], 30'd0, 3'd0} >> 3;
          div_d_q   <= sq_res_q[31:0];
          div_r_q   <= '0;
          cnt_q     <= '0;
          div_ret_q <= StUDivb;
          st_q      <= StDiv;
        end
        StUDivb: begin
          qa_q      <= div_quo_q[31:0];
          div_n_q   <= {3'd0, mb_q[30:0], 30'd0};
          div_d_q   <= len_q;
          div_r_q   <= '0;
          cnt_q     <= '0;
          div_ret_q <= StUEnd;
          st_q      <= StDiv;
        end
        StUEnd: begin
          if (!phase_sum_q) begin
            // left normal of the edge: (-uy, ux)
            n2x_q <= b_q[33] ? 32'(div_quo_q[31:0]) : 32'(-div_quo_q[31:0]);
            n2y_q <= a_q[33] ? 32'(-qa_q) : 32'(qa_q);
            if (held_q == 2'd1) begin
              nx_q <= b_q[33] ? 53'(div_quo_q[31:0]) : -53'(div_quo_q[31:0]);
              ny_q <= a_q[33] ? -53'(qa_q) : 53'(qa_q);
              cy_q <= 1'b0;
              st_q <= StMlo;
            end else begin
              a_q         <= 34'(n1x_q) + (b_q[33] ? 34'(div_quo_q[31:0])
                                                   : -34'(div_quo_q[31:0]));
              b_q         <= 34'(n1y_q) + (a_q[33] ? -34'(qa_q) : 34'(qa_q));
              phase_sum_q <= 1'b1;
              st_q        <= StUInit;
            end
          end else begin
            nx_q <= a_q[33] ? -53'(qa_q) : 53'(qa_q);
            ny_q <= b_q[33] ? -53'(div_quo_q[31:0]) : 53'(div_quo_q[31:0]);
            st_q <= StDota;
          end
        end
        StDiv: begin
          div_n_q   <= div_n_q << 1;
          div_r_q   <= div_ge ? 32'(div_t - {1'b0, div_d_q}) : div_t[31:0];
          div_quo_q <= {div_quo_q[62:0], div_ge};
          cnt_q     <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            st_q <= div_ret_q;
          end
        end
        StDota: st_q <= StDotb;
        StDotb: begin
          acc_q <= prod_q;
          st_q  <= StDots;
        end
        StDots: begin
          cy_q <= 1'b0;
          if (dot > CosLimitQ60) begin
            cq_q <= 32'(dot >>> 30);
            st_q <= StMdivx;
          end else begin
            st_q <= StMlo;
          end
        end
        StMdivx: begin
          div_n_q   <= {3'd0, (nx_q[52] ? 31'(-nx_q) : nx_q[30:0]), 30'd0};
          div_d_q   <= cq_q;
          div_r_q   <= '0;
          cnt_q     <= '0;
          div_ret_q <= StMdivy;
          st_q      <= StDiv;
        end
        StMdivy: begin
          nx_q      <= nx_q[52] ? -53'(div_quo_q[51:0]) : 53'(div_quo_q[51:0]);
          div_n_q   <= {3'd0, (ny_q[52] ? 31'(-ny_q) : ny_q[30:0]), 30'd0};
          div_d_q   <= cq_q;
          div_r_q   <= '0;
          cnt_q     <= '0;
          div_ret_q <= StMdend;
          st_q      <= StDiv;
        end
        StMdend: begin
          ny_q <= ny_q[52] ? -53'(div_quo_q[51:0]) : 53'(div_quo_q[51:0]);
          st_q <= StMlo;
        end
        StMlo: st_q <= StMhi;
        StMhi: begin
          lo_q <= prod_q;
          st_q <= StMacc;
        end
        StMacc: begin
          if (!cy_q) begin
            sx_q <= coord_sat;
            cy_q <= 1'b1;
            st_q <= StMlo;
          end else begin
            sy_q <= coord_sat;
            st_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_q.shifted_x    <= sx_q;
            out_q.shifted_y    <= sy_q;
            out_q.shifted_z    <= emit_sel_q ? p_q.point_z : pend_z_q;
            out_q.shifted_last <= emit_sel_q;
            out_valid_q        <= 1'b1;
            if (emit_sel_q) begin
              held_q <= 2'd0;
              st_q   <= StIdle;
            end else if (p_q.point_last) begin
              // the last point itself takes the last edge's normal
              emit_sel_q <= 1'b1;
              nx_q       <= 53'(n2x_q);
              ny_q       <= 53'(n2y_q);
              cy_q       <= 1'b0;
              st_q       <= StMlo;
            end else begin
              pend_x_q <= p_q.point_x;
              pend_y_q <= p_q.point_y;
              pend_z_q <= p_q.point_z;
              n1x_q    <= n2x_q;
              n1y_q    <= n2y_q;
              held_q   <= 2'd2;
              st_q     <= StIdle;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

// File: tb/tb_polyline_normal_offset.sv
// testbench for polyline_normal_offset: random and directed polylines, a
// bit-accurate miter offset predictor and a scoreboard; depends on pno_pkg
module tb_polyline_normal_offset;
  import pno_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 700;
  localparam int unsigned LongHold      = 3000;
  localparam longint unsigned ShiftClamp = 64'd1 << 62;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  pno_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  pno_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic signed [31:0] cfg_data_i;

  polyline_normal_offset i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  pno_in_t  point_queue[$];
  pno_out_t shifted_queue[$];
  int unsigned errors = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 0;

  // predictor state
  logic signed [31:0] offset_mm;
  logic signed [31:0] earlier_pt[3];
  logic signed [31:0] pending_pt[3];
  int held;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic unit_q30(input longint a, input longint b, output longint ux,
                          output longint uy);
    longint unsigned ma, mb, m, len, qa, qb;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    m = (ma > mb) ? ma : mb;
    if (m == 0) begin
      ux = 0;
      uy = 0;
      return;
    end
    while (m >= (64'd1 << 31)) begin
      ma >>= 1; mb >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      ma <<= 1; mb <<= 1; m <<= 1;
    end
    len = floor_sqrt(ma * ma + mb * mb);
    qa = (ma << 30) / len;
    qb = (mb << 30) / len;
    ux = (a < 0) ? -longint'(qa) : longint'(qa);
    uy = (b < 0) ? -longint'(qb) : longint'(qb);
  endtask

  task automatic left_normal(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] qx, input logic signed [31:0] qy,
                             output longint nx, output longint ny);
    longint ux, uy;
    unit_q30(longint'(qx) - longint'(px), longint'(qy) - longint'(py), ux, uy);
    nx = -uy;
    ny = ux;
  endtask

  function automatic logic signed [31:0] shift_coord(logic signed [31:0] c, longint n);
    longint off, delta, r;
    longint unsigned a, b, prod, q;
    bit neg;
    off = longint'(offset_mm);
    a = (n < 0) ? longint'(-n) : n;
    b = (off < 0) ? longint'(-off) : off;
    neg = (n < 0) != (off < 0);
    if (b != 0 && a > ShiftClamp / b) prod = ShiftClamp;
    else prod = a * b;
    q = (prod + (64'd1 << 29)) >> 30;
    delta = neg ? -longint'(q) : longint'(q);
    r = longint'(c) + delta;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic pno_out_t shifted_point(logic signed [31:0] p[3], longint nx,
                                             longint ny, bit last);
    pno_out_t o;
    o.shifted_x = shift_coord(p[0], nx);
    o.shifted_y = shift_coord(p[1], ny);
    o.shifted_z = p[2];
    o.shifted_last = last;
    return o;
  endfunction

  task automatic predict_offset(input pno_in_t it);
    logic signed [31:0] p[3];
    longint n1x, n1y, n2x, n2y, nx, ny, dot, cq;
    pno_out_t o;
    p[0] = it.point_x;
    p[1] = it.point_y;
    p[2] = it.point_z;
    if (held == 0) begin
      if (it.point_last) begin
        o.shifted_x = p[0];
        o.shifted_y = p[1];
        o.shifted_z = p[2];
        o.shifted_last = 1'b1;
        shifted_queue.push_back(o);
      end else begin
        pending_pt = p;
        held = 1;
      end
      return;
    end
    left_normal(pending_pt[0], pending_pt[1], p[0], p[1], n2x, n2y);
    if (held == 1) begin
      shifted_queue.push_back(shifted_point(pending_pt, n2x, n2y, 1'b0));
    end else begin
      left_normal(earlier_pt[0], earlier_pt[1], pending_pt[0], pending_pt[1], n1x, n1y);
      unit_q30(n1x + n2x, n1y + n2y, nx, ny);
      dot = n1x * nx + n1y * ny;
      // miter: stretch by 1/cos of the half angle
      if (dot > CosLimitQ60) begin
        cq = dot >>> 30;
        nx = nx * 64'sd1073741824 / cq;
        ny = ny * 64'sd1073741824 / cq;
      end
      shifted_queue.push_back(shifted_point(pending_pt, nx, ny, 1'b0));
    end
    if (it.point_last) begin
      shifted_queue.push_back(shifted_point(p, n2x, n2y, 1'b1));
      held = 0;
    end else begin
      earlier_pt = pending_pt;
      pending_pt = p;
      held = 2;
    end
  endtask

  // driver
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_gap = 0;
      held = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) predict_offset(in_data_i);
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (point_queue.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 16);
        in_valid_i <= 1'b0;
      end else if (point_queue.size() > 0) begin
        in_data_i <= point_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int unsigned out_stall = 0;
  int unsigned beats_seen = 0;
  bit long_hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pno_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        if (shifted_queue.size() == 0) begin
          $error("unexpected beat x=%0d y=%0d", out_data_o.shifted_x, out_data_o.shifted_y);
          errors++;
        end else begin
          want = shifted_queue.pop_front();
          if (out_data_o.shifted_x !== want.shifted_x) begin
            $error("shifted_x exp %0d got %0d", want.shifted_x, out_data_o.shifted_x);
            errors++;
          end
          if (out_data_o.shifted_y !== want.shifted_y) begin
            $error("shifted_y exp %0d got %0d", want.shifted_y, out_data_o.shifted_y);
            errors++;
          end
          if (out_data_o.shifted_z !== want.shifted_z) begin
            $error("shifted_z exp %0d got %0d", want.shifted_z, out_data_o.shifted_z);
            errors++;
          end
          if (out_data_o.shifted_last !== want.shifted_last) begin
            $error("shifted_last exp %0b got %0b", want.shifted_last,
                   out_data_o.shifted_last);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && beats_seen >= 150) begin
        // long hold so the block backs up into its input
        long_hold_done = 1;
        out_stall = LongHold;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = $urandom_range(1, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // config handshakes, offset tracking and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_mm <= '0;
      idle_cycles = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        offset_mm <= cfg_data_i;
        cfg_writes++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {{8{1'b0}}, 24'($urandom)} - 32'sd8388608;
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      default: return 32'($urandom_range(0, 2000000)) - 32'sd1000000;
    endcase
  endfunction

  task automatic push_point(logic signed [31:0] x, logic signed [31:0] y, bit last);
    pno_in_t it;
    it.point_x = x;
    it.point_y = y;
    it.point_z = $urandom;
    it.point_last = last;
    point_queue.push_back(it);
  endtask

  // random walk with repeats and reversals so corners of every kind show up
  task automatic push_line(int len);
    logic signed [31:0] x, y, dx, dy;
    x = pick_coord();
    y = pick_coord();
    dx = 0;
    dy = 0;
    for (int i = 0; i < len; i++) begin
      push_point(x, y, i == len - 1);
      case ($urandom_range(0, 9))
        0: begin dx = 0; dy = 0; end
        1: begin dx = -dx; dy = -dy; end
        2: ;
        3: begin x = pick_coord(); y = pick_coord(); end
        default: begin
          dx = 32'($urandom_range(0, 400000)) - 32'sd200000;
          dy = 32'($urandom_range(0, 400000)) - 32'sd200000;
        end
      endcase
      x = x + dx;
      y = y + dy;
    end
  endtask

  task automatic write_offset(logic signed [31:0] v);
    int unsigned seen;
    seen = cfg_writes;
    @(posedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    wait (cfg_writes != seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    wait (point_queue.size() == 0 && !in_valid_i && shifted_queue.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  logic signed [31:0] offsets[6];
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    offsets[0] = 32'sh00010000;
    offsets[1] = 32'sh7fffffff;
    offsets[2] = 32'sh80000000;
    offsets[3] = -32'sd300000;
    offsets[4] = $urandom;
    offsets[5] = 32'sd0;
    // directed: reset offset, then single point, two points, zero edge,
    // reversal, right angle, extremes
    push_point(32'sd100, -32'sd5, 1'b1);
    settle();
    write_offset(offsets[0]);
    push_point(0, 0, 1'b0);
    push_point(32'sh00010000, 0, 1'b1);
    push_point(0, 0, 1'b0);
    push_point(0, 0, 1'b0);
    push_point(32'sh00050000, 0, 1'b0);
    push_point(32'sh00050000, 0, 1'b1);
    push_point(0, 0, 1'b0);
    push_point(32'sh00020000, 0, 1'b0);
    push_point(0, 0, 1'b0);
    push_point(0, 32'sh00030000, 1'b0);
    push_point(32'sh00010000, 32'sh00030001, 1'b1);
    push_point(32'sh80000000, 32'sh80000000, 1'b0);
    push_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    push_point(32'sh80000000, 32'sh7fffffff, 1'b1);
    push_point(32'sh7fffffff, 32'sh80000000, 1'b1);
    settle();
    for (int ph = 1; ph < 6; ph++) begin
      write_offset(offsets[ph]);
      quiet = (ph == 5);
      for (int n = 0; n < 300;) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        push_line(len);
        n += len;
      end
      settle();
    end
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
